[rtl/pbcs_pkg.sv]
package pbcs_pkg;

   localparam int SPACE_BYTES = 256;
   localparam int MEM_DEPTH   = 2 * SPACE_BYTES;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);

   localparam logic [2:0]  FN_HOST          = 3'd0;
   localparam logic [2:0]  FN_BRIDGE        = 3'd1;
   localparam logic [7:0]  BYTE_ABSENT      = 8'hff;
   localparam logic [7:0]  OFF_CMD          = 8'h04;
   localparam logic [7:0]  OFF_STATUS       = 8'h07;
   localparam logic [7:0]  OFF_HOST_12      = 8'h12;
   localparam logic [7:0]  OFF_BR_MEM_BASE  = 8'h20;
   localparam logic [7:0]  OFF_BR_MEM_LIMIT = 8'h22;
   localparam logic [7:0]  OFF_BR_PF_BASE   = 8'h24;
   localparam logic [7:0]  OFF_BR_PF_LIMIT  = 8'h26;
   localparam logic [7:0]  OFF_SHADOW_LO    = 8'h61;
   localparam logic [7:0]  OFF_SHADOW_MI    = 8'h62;
   localparam logic [7:0]  OFF_SHADOW_HI    = 8'h63;
   localparam logic [7:0]  HOST_CMD_MASK    = 8'h40;
   localparam logic [7:0]  HOST_W1C_MASK    = 8'hb0;
   localparam logic [7:0]  BR_CMD_MASK      = 8'h47;
   localparam logic [7:0]  BR_W1C_MASK      = 8'h30;
   localparam logic [7:0]  HI_NIBBLE        = 8'hf0;
   localparam logic [19:0] BASE_C0000       = 20'hc0000;
   localparam logic [19:0] BASE_D0000       = 20'hd0000;
   localparam logic [19:0] BASE_E0000       = 20'he0000;
   localparam logic [19:0] BASE_F0000       = 20'hf0000;
   localparam logic [16:0] SIZE_64K         = 17'h10000;
   localparam logic [16:0] SIZE_16K         = 17'h04000;
   localparam logic        MODE_READ        = 1'b0;
   localparam logic        MODE_WRITE       = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [2:0] function_number;
      logic [7:0] register_offset;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        map_valid;
      logic [19:0] region_base;
      logic [16:0] region_size;
      logic        read_internal;
      logic        write_internal;
      logic        shadow_bios;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_UPDATE,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      logic init_wr;
      logic load_req;
      logic update;
      logic advance;
   } ctl_cmd_type;

   typedef struct packed {
      logic init_last;
      logic last;
   } ctl_status_type;

   // power-on contents; function 1 lives at the upper half
   function automatic logic [7:0] cfg_default(input logic [MEM_AW-1:0] idx);
      logic [7:0] d;
      d = 8'h00;
      case (idx)
         9'h000, 9'h003: d = 8'h06;
         9'h001:         d = 8'h11;
         9'h002:         d = 8'h91;
         9'h004:         d = 8'h06;
         9'h010:         d = 8'h08;
         9'h034:         d = 8'ha0;
         9'h056, 9'h057, 9'h05a, 9'h05b, 9'h05c, 9'h05d, 9'h05e, 9'h05f: d = 8'h01;
         9'h064, 9'h065, 9'h066: d = 8'hec;
         9'h067, 9'h06b: d = 8'h01;
         9'h0a4:         d = 8'h03;
         9'h0a5:         d = 8'h02;
         9'h0a7:         d = 8'h07;
         9'h100, 9'h103: d = 8'h06;
         9'h101:         d = 8'h11;
         9'h102:         d = 8'h91;
         9'h104:         d = 8'h07;
         9'h106:         d = 8'h20;
         9'h107:         d = 8'h02;
         9'h10a:         d = 8'h04;
         9'h10b:         d = 8'h06;
         9'h10e:         d = 8'h01;
         9'h11c, 9'h120, 9'h124: d = 8'hf0;
         9'h121, 9'h125: d = 8'hff;
         default:        d = 8'h00;
      endcase
      return d;
   endfunction

endpackage

[rtl/pbcs_ctrl.sv]
module pbcs_ctrl
   import pbcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready && status.last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_RESP: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !status.last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_final_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && status.last |=> req_ready)
      else $error("no return to idle after final beat");
   a_init_closed: assert property (@(posedge clock) disable iff (reset)
      cmd.init_wr |-> !req_ready && !rsp_valid) else $error("port open during init");

endmodule

[rtl/pbcs_datapath.sv]
module pbcs_datapath
   import pbcs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   input  req_type        req,
   output rsp_type        rsp
);

   logic [7:0]        cfg_mem_ff [MEM_DEPTH];
   logic [7:0]        rd_data_ff;
   req_type           req_ff;
   logic [MEM_AW-1:0] init_cnt_ff, init_cnt_in;
   logic [3:0]        pend_ff, pend_in;
   logic              sel63_ff, sel63_in;
   logic              hi_ff, hi_in;
   logic [7:0]        val_ff, val_in;
   logic [7:0]        rbyte_ff, rbyte_in;
   logic              bios_ff, bios_in;

   logic [7:0]        old_b, wr_v, new_b, diff;
   logic [7:0]        off;
   logic              wr_en;
   logic [3:0]        ev_mask;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [1:0]        ev_idx;
   logic [1:0]        route;
   logic              ev_last;

   function automatic logic host_ro(input logic [7:0] a);
      return a < 8'h04 || (a >= 8'h05 && a < 8'h07) || (a >= 8'h08 && a < 8'h0d) ||
             (a >= 8'h0e && a < 8'h12) || (a >= 8'h14 && a < 8'h50) ||
             (a >= 8'h79 && a < 8'h7e) || (a >= 8'h85 && a < 8'h88) ||
             (a >= 8'h8c && a < 8'ha8) || (a >= 8'had && a < 8'hfd);
   endfunction

   function automatic logic bridge_ro(input logic [7:0] a);
      return a < 8'h04 || (a >= 8'h05 && a < 8'h07) || (a >= 8'h08 && a < 8'h18) ||
             a == 8'h1b || (a >= 8'h1e && a < 8'h20) ||
             (a >= 8'h28 && a < 8'h3e) || a >= 8'h43;
   endfunction

   // write merge on the fetched byte
   always_comb begin
      old_b   = rd_data_ff;
      wr_v    = req_ff.write_data;
      off     = req_ff.register_offset;
      diff    = old_b ^ wr_v;
      new_b   = wr_v;
      wr_en   = 1'b0;
      ev_mask = '0;
      if (req_ff.mode == MODE_WRITE && req_ff.function_number == FN_HOST) begin
         wr_en = !host_ro(off);
         case (off)
            OFF_CMD:     new_b = (old_b & ~HOST_CMD_MASK) | (wr_v & HOST_CMD_MASK);
            OFF_STATUS:  new_b = old_b & ~(wr_v & HOST_W1C_MASK);
            OFF_HOST_12: new_b = wr_v & HI_NIBBLE;
            OFF_SHADOW_LO, OFF_SHADOW_MI: begin
               ev_mask = {|diff[7:6], |diff[5:4], |diff[3:2], |diff[1:0]};
            end
            OFF_SHADOW_HI: begin
               ev_mask = {|diff[7:6], |diff[5:4], 2'b00};
            end
            default:     new_b = wr_v;
         endcase
         if (!wr_en) ev_mask = '0;
      end else if (req_ff.mode == MODE_WRITE && req_ff.function_number == FN_BRIDGE) begin
         wr_en = !bridge_ro(off);
         case (off)
            OFF_CMD:    new_b = (old_b & ~BR_CMD_MASK) | (wr_v & BR_CMD_MASK);
            OFF_STATUS: new_b = old_b & ~(wr_v & BR_W1C_MASK);
            OFF_BR_MEM_BASE, OFF_BR_MEM_LIMIT, OFF_BR_PF_BASE, OFF_BR_PF_LIMIT:
               new_b = wr_v & HI_NIBBLE;
            default:    new_b = wr_v;
         endcase
      end
   end

   always_comb begin
      mem_we    = cmd.init_wr || (cmd.update && wr_en);
      mem_waddr = cmd.init_wr ? init_cnt_ff : {req_ff.function_number[0], off};
      mem_wdata = cmd.init_wr ? cfg_default(init_cnt_ff) : new_b;
   end

   always_ff @(posedge clock) begin
      if (mem_we) cfg_mem_ff[mem_waddr] <= mem_wdata;
      if (cmd.load_req) begin
         rd_data_ff <= cfg_mem_ff[{req.function_number[0], req.register_offset}];
      end
   end

   always_comb begin
      init_cnt_in = cmd.init_wr ? init_cnt_ff + 1'b1 : init_cnt_ff;
      pend_in     = pend_ff;
      sel63_in    = sel63_ff;
      hi_in       = hi_ff;
      val_in      = val_ff;
      rbyte_in    = rbyte_ff;
      bios_in     = bios_ff;
      if (cmd.update) begin
         pend_in  = ev_mask;
         sel63_in = (off == OFF_SHADOW_HI);
         hi_in    = (off == OFF_SHADOW_MI);
         val_in   = wr_v;
         if (req_ff.mode == MODE_READ) begin
            rbyte_in = (req_ff.function_number <= FN_BRIDGE) ? old_b : BYTE_ABSENT;
         end else begin
            rbyte_in = 8'h00;
         end
         if (ev_mask[2] && off == OFF_SHADOW_HI) bios_in = wr_v[5];
      end else if (cmd.advance) begin
         pend_in = pend_ff & (pend_ff - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
         pend_ff     <= '0;
         sel63_ff    <= 1'b0;
         bios_ff     <= 1'b0;
      end else begin
         init_cnt_ff <= init_cnt_in;
         pend_ff     <= pend_in;
         sel63_ff    <= sel63_in;
         bios_ff     <= bios_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req;
      hi_ff    <= hi_in;
      val_ff   <= val_in;
      rbyte_ff <= rbyte_in;
   end

   // lowest pending region goes out first
   always_comb begin
      ev_idx = 2'd3;
      if (pend_ff[0])      ev_idx = 2'd0;
      else if (pend_ff[1]) ev_idx = 2'd1;
      else if (pend_ff[2]) ev_idx = 2'd2;
      case (ev_idx)
         2'd0:    route = val_ff[1:0];
         2'd1:    route = val_ff[3:2];
         2'd2:    route = val_ff[5:4];
         default: route = val_ff[7:6];
      endcase
      ev_last = (pend_ff & (pend_ff - 4'd1)) == 4'd0;
   end

   always_comb begin
      rsp             = '0;
      rsp.read_data   = rbyte_ff;
      rsp.shadow_bios = bios_ff;
      rsp.last        = ev_last;
      if (|pend_ff) begin
         rsp.map_valid      = 1'b1;
         rsp.read_internal  = route[1];
         rsp.write_internal = route[0];
         if (sel63_ff) begin
            rsp.region_base = ev_idx[0] ? BASE_E0000 : BASE_F0000;
            rsp.region_size = SIZE_64K;
         end else begin
            rsp.region_base = (hi_ff ? BASE_D0000 : BASE_C0000) + {4'd0, ev_idx, 14'd0};
            rsp.region_size = SIZE_16K;
         end
      end
   end

   assign status.init_last = cmd.init_wr && (init_cnt_ff == MEM_AW'(MEM_DEPTH - 1));
   assign status.last      = ev_last;

   a_hi_fields: assert property (@(posedge clock) disable iff (reset)
      sel63_ff |-> pend_ff[1:0] == 2'b00) else $error("low event on top shadow byte");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> $countones(pend_ff) == $countones($past(pend_ff)) - 1)
      else $error("event dropped or repeated");
   a_pend_load: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> pend_ff == $past(ev_mask)) else $error("event set not loaded");

endmodule

[rtl/pci_bridge_config_space.sv]
// Configuration space of a two-function north bridge (host bridge and
// PCI-to-PCI bridge, 256 bytes each).
// req_* carries one access beat: read or write of one byte at a function
// and offset. rsp_* returns the results of that access: one beat for a read
// or for a write that changes no shadow routing, otherwise one beat per
// changed shadow region (up to four), the last one flagged by last.
// Steps: the accepted request fetches its byte from the configuration RAM,
// the UPDATE state merges and writes it back and loads the map events, and
// the RESP state sends the result beats one event at a time. One access at
// a time: req_ready stays low from acceptance until the last beat is taken.
// Reset: the RAM is loaded with its power-on contents, all 512 bytes, one
// byte per cycle; req_ready stays low until that is done.
// A stalled rsp_ready holds the result beat and keeps req_ready low.
module pci_bridge_config_space
   import pbcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   pbcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pbcs_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req_data),
      .rsp    (rsp_data)
   );

endmodule
